// ===== rtl/assert_macros.svh =====
// assertion macros shared by the scheduler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold in the cycle after the trigger
`define ASSERT_NEXT(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("assertion failed");

// property must hold in the same cycle as the trigger
`define ASSERT_SAME(label, clk, rst_n, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error("assertion failed");

`endif

// ===== rtl/pts_pkg.sv =====
// shared constants and types of the priority task scheduler
package pts_pkg;
    localparam int NUM_PRIOS = 32;
    localparam int NUM_TASKS = 16;
    localparam int PW = $clog2(NUM_PRIOS);
    localparam int TW = $clog2(NUM_TASKS);
    localparam int CW = $clog2(NUM_TASKS + 1);
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [7:0] SLICE_RESET = 8'd10;

    localparam logic [2:0] ACT_READY    = 3'd0;
    localparam logic [2:0] ACT_UNREADY  = 3'd1;
    localparam logic [2:0] ACT_DELAY    = 3'd2;
    localparam logic [2:0] ACT_WAKE     = 3'd3;
    localparam logic [2:0] ACT_TICK     = 3'd4;
    localparam logic [2:0] ACT_LOCK     = 3'd5;
    localparam logic [2:0] ACT_UNLOCK   = 3'd6;
    localparam logic [2:0] ACT_SCHEDULE = 3'd7;

    // per task record kept in the task memory
    typedef struct packed {
        logic [TW-1:0] rnext;
        logic [TW-1:0] rprev;
        logic [PW-1:0] prio;
        logic [31:0]   remain;
        logic [TW-1:0] dnext;
    } task_rec_t;

    // per priority queue record kept in the queue memory
    typedef struct packed {
        logic [TW-1:0] head;
        logic [TW-1:0] tail;
    } queue_rec_t;

    // memory port request
    typedef struct packed {
        logic          we;
        logic [TW-1:0] addr;
        task_rec_t     wdata;
    } tmem_req_t;

    typedef struct packed {
        logic          we;
        logic [PW-1:0] addr;
        queue_rec_t    wdata;
    } qmem_req_t;

    function automatic logic [PW-1:0] first_set(input logic [NUM_PRIOS-1:0] v);
        logic [PW-1:0] r;
        r = '0;
        for (int i = NUM_PRIOS - 1; i >= 0; i--) begin
            if (v[i]) r = PW'(i);
        end
        return r;
    endfunction
endpackage

// ===== rtl/pts_task_mem.sv =====
// task record memory, one write port and one registered read port
module pts_task_mem import pts_pkg::*; (
    input  logic      clk,
    input  tmem_req_t wreq,
    input  logic [TW-1:0] raddr,
    output task_rec_t rdata
);
    task_rec_t mem [NUM_TASKS];

    always_ff @(posedge clk)
    begin
        if (wreq.we)
        begin
            mem[wreq.addr] <= wreq.wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/pts_queue_mem.sv =====
// ready queue head and tail memory, one write port and one registered read port
module pts_queue_mem import pts_pkg::*; (
    input  logic      clk,
    input  qmem_req_t wreq,
    input  logic [PW-1:0] raddr,
    output queue_rec_t rdata
);
    queue_rec_t mem [NUM_PRIOS];

    always_ff @(posedge clk)
    begin
        if (wreq.we)
        begin
            mem[wreq.addr] <= wreq.wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== rtl/priority_task_scheduler_unit.sv =====
// top level of the priority task scheduler: sequencer around two record memories
//
// Priority task scheduler. One request is taken at a time and gives one result, and
// a new request is taken only after the previous result has been accepted. The task
// records (ready links, priority, delay count, delay link) and the per priority queue
// head and tail sit in two synchronous memories with one read and one write port each;
// a sequencer reads, modifies and writes them one access per cycle. Wake walks the
// delay list to find the task and unlinks it. A tick walks the whole delay list,
// counts each task down and unlinks each one that expires, appending it to its ready
// queue if it is not there yet; it then counts down the time slice of the current
// task and selects the task to run. The single read port of the task memory
// serialises the record accesses. Queue counts, the ready bitmap, the membership and
// delayed bits and the time slices live in flops.
`include "assert_macros.svh"
module priority_task_scheduler_unit import pts_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  action,
    input  logic [3:0]  task_id,
    input  logic [4:0]  task_prio,
    input  logic [31:0] delay_ticks,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        switch_now,
    output logic [3:0]  running_task,
    output logic        none_ready,
    output logic [7:0]  lock_depth
);
    // sequencer states
    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_DISP   = 6'd1;
    localparam logic [5:0] S_APP0   = 6'd2;   // read queue of task prio
    localparam logic [5:0] S_APP1   = 6'd3;   // got queue rec
    localparam logic [5:0] S_APP2   = 6'd4;   // patch tail rnext
    localparam logic [5:0] S_APP3   = 6'd5;   // patch task rprev
    localparam logic [5:0] S_APP4   = 6'd6;   // return to caller
    localparam logic [5:0] S_REM0   = 6'd7;   // task rec read wait
    localparam logic [5:0] S_REM1   = 6'd8;   // queue rec read wait
    localparam logic [5:0] S_REM2   = 6'd9;   // decide
    localparam logic [5:0] S_REM3   = 6'd10;  // patch prev rnext
    localparam logic [5:0] S_REM5   = 6'd12;  // read next
    localparam logic [5:0] S_REM6   = 6'd13;  // patch next rprev
    localparam logic [5:0] S_REM7   = 6'd14;  // write queue rec
    localparam logic [5:0] S_DLY0   = 6'd15;
    localparam logic [5:0] S_DTL0   = 6'd17;  // read dl tail
    localparam logic [5:0] S_DTL1   = 6'd18;
    localparam logic [5:0] S_WAK0   = 6'd19;  // walk read issue
    localparam logic [5:0] S_WAK1   = 6'd20;
    localparam logic [5:0] S_UNL0   = 6'd22;  // unlink: read prev
    localparam logic [5:0] S_UNL1   = 6'd23;
    localparam logic [5:0] S_UNL2   = 6'd24;
    localparam logic [5:0] S_TCK0   = 6'd25;  // tick walk read issue
    localparam logic [5:0] S_TCK1   = 6'd26;
    localparam logic [5:0] S_TCK2   = 6'd27;
    localparam logic [5:0] S_TCK3   = 6'd28;  // advance walk after decrement, unlink or append
    localparam logic [5:0] S_SLC0   = 6'd29;
    localparam logic [5:0] S_SLC1   = 6'd30;
    localparam logic [5:0] S_SCH0   = 6'd31;
    localparam logic [5:0] S_SCH1   = 6'd32;
    localparam logic [5:0] S_SCH2   = 6'd33;
    localparam logic [5:0] S_DONE   = 6'd34;

    // return codes for the shared append, remove and unlink subroutines
    localparam logic [1:0] R_DONE  = 2'd0;
    localparam logic [1:0] R_TICK  = 2'd1;
    localparam logic [1:0] R_SLICE = 2'd2;

    logic [5:0]  state_reg, state_next;
    logic [1:0]  ret_reg, ret_next;
    logic [7:0]  reload_reg;
    logic [2:0]  act_reg, act_next;
    logic [TW-1:0] tid_reg, tid_next;
    logic [PW-1:0] prio_reg, prio_next;
    logic [31:0] ticks_reg, ticks_next;
    logic [NUM_PRIOS-1:0] bitmap_reg, bitmap_next;
    logic [CW-1:0] qcount_reg [NUM_PRIOS];
    logic [CW-1:0] qcount_next [NUM_PRIOS];
    logic [NUM_TASKS-1:0] inready_reg, inready_next;
    logic [NUM_TASKS-1:0] delayed_reg, delayed_next;
    logic [7:0]  slice_reg [NUM_TASKS];
    logic [7:0]  slice_next [NUM_TASKS];
    logic [TW-1:0] cur_reg, cur_next;
    logic [7:0]  lock_reg, lock_next;
    logic [31:0] ticktot_reg, ticktot_next;
    logic [TW-1:0] dlhead_reg, dlhead_next, dltail_reg, dltail_next;
    logic [CW-1:0] dllen_reg, dllen_next;
    // walk state
    logic [CW-1:0] n_reg, n_next;
    logic [TW-1:0] wt_reg, wt_next, wprev_reg, wprev_next, wnx_reg, wnx_next;
    logic        hprev_reg, hprev_next;
    logic [TW-1:0] wtask_reg, wtask_next;   // task under append or remove
    task_rec_t   rec_reg, rec_next;
    queue_rec_t  qrec_reg, qrec_next;
    logic        sw_reg, sw_next;
    logic        ov_reg, ov_next;

    tmem_req_t   twr;
    logic [TW-1:0] traddr;
    task_rec_t   trd;
    qmem_req_t   qwr;
    logic [PW-1:0] qraddr;
    queue_rec_t  qrd;

    pts_task_mem u_tmem (.clk(clk), .wreq(twr), .raddr(traddr), .rdata(trd));
    pts_queue_mem u_qmem (.clk(clk), .wreq(qwr), .raddr(qraddr), .rdata(qrd));

    assign in_stall     = (state_reg != S_IDLE) || ov_reg;
    assign out_valid    = ov_reg;
    assign switch_now   = sw_reg;
    assign running_task = cur_reg;
    assign none_ready   = (bitmap_reg == '0);
    assign lock_depth   = lock_reg;

    logic [PW-1:0] wprio;
    assign wprio = rec_reg.prio;

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        act_next     = act_reg;
        tid_next     = tid_reg;
        prio_next    = prio_reg;
        ticks_next   = ticks_reg;
        bitmap_next  = bitmap_reg;
        qcount_next  = qcount_reg;
        inready_next = inready_reg;
        delayed_next = delayed_reg;
        slice_next   = slice_reg;
        cur_next     = cur_reg;
        lock_next    = lock_reg;
        ticktot_next = ticktot_reg;
        dlhead_next  = dlhead_reg;
        dltail_next  = dltail_reg;
        dllen_next   = dllen_reg;
        n_next       = n_reg;
        wt_next      = wt_reg;
        wprev_next   = wprev_reg;
        wnx_next     = wnx_reg;
        hprev_next   = hprev_reg;
        wtask_next   = wtask_reg;
        rec_next     = rec_reg;
        qrec_next    = qrec_reg;
        sw_next      = sw_reg;
        ov_next      = ov_reg;
        twr          = '0;
        qwr          = '0;
        traddr       = wtask_reg;
        qraddr       = wprio;

        if (ov_reg && !out_stall)
        begin
            ov_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                traddr = task_id;
                if (in_valid && !ov_reg)
                begin
                    act_next   = action;
                    tid_next   = task_id;
                    prio_next  = task_prio;
                    ticks_next = (delay_ticks == 32'd0) ? 32'd1 : delay_ticks;
                    wtask_next = task_id;
                    sw_next    = 1'b0;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                // task record of tid is on trd
                rec_next = trd;
                case (act_reg)
                    ACT_READY:
                    begin
                        if (inready_reg[tid_reg])
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            rec_next.prio = prio_reg;
                            twr.we = 1'b1;
                            twr.addr = tid_reg;
                            twr.wdata = trd;
                            twr.wdata.prio = prio_reg;
                            ret_next = R_DONE;
                            state_next = S_APP0;
                        end
                    end
                    ACT_UNREADY:
                    begin
                        ret_next = R_DONE;
                        state_next = inready_reg[tid_reg] ? S_REM1 : S_DONE;
                        qraddr = trd.prio;
                    end
                    ACT_DELAY:
                    begin
                        twr.we = 1'b1;
                        twr.addr = tid_reg;
                        twr.wdata = trd;
                        twr.wdata.remain = ticks_reg;
                        rec_next.remain = ticks_reg;
                        if (delayed_reg[tid_reg])
                        begin
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = (dllen_reg == '0) ? S_DLY0 : S_DTL0;
                        end
                    end
                    ACT_WAKE:
                    begin
                        if (delayed_reg[tid_reg])
                        begin
                            n_next = dllen_reg;
                            wt_next = dlhead_reg;
                            hprev_next = 1'b0;
                            wprev_next = '0;
                            state_next = S_WAK0;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    ACT_TICK:
                    begin
                        n_next = dllen_reg;
                        wt_next = dlhead_reg;
                        hprev_next = 1'b0;
                        wprev_next = '0;
                        state_next = S_TCK0;
                    end
                    ACT_LOCK:
                    begin
                        if (lock_reg != LOCK_MAX) lock_next = lock_reg + 8'd1;
                        state_next = S_DONE;
                    end
                    ACT_UNLOCK:
                    begin
                        if (lock_reg != 8'd0)
                        begin
                            lock_next = lock_reg - 8'd1;
                            state_next = (lock_reg == 8'd1) ? S_SCH0 : S_DONE;
                        end
                        else
                        begin
                            state_next = S_DONE;
                        end
                    end
                    default:
                    begin
                        state_next = S_SCH0;
                    end
                endcase
            end
            // append wtask (record in rec_reg) to its ready queue
            S_APP0:
            begin
                qraddr = wprio;
                state_next = S_APP1;
            end
            S_APP1:
            begin
                qrec_next = qrd;
                qwr.we = 1'b1;
                qwr.addr = wprio;
                qwr.wdata.tail = wtask_reg;
                if (qcount_reg[wprio] == '0)
                begin
                    qwr.wdata.head = wtask_reg;
                    state_next = S_APP4;
                end
                else
                begin
                    qwr.wdata.head = qrd.head;
                    traddr = qrd.tail;
                    state_next = S_APP2;
                end
                qcount_next[wprio] = qcount_reg[wprio] + CW'(1);
                bitmap_next[wprio] = 1'b1;
                inready_next[wtask_reg] = 1'b1;
            end
            S_APP2:
            begin
                twr.we = 1'b1;
                twr.addr = qrec_reg.tail;
                twr.wdata = trd;
                twr.wdata.rnext = wtask_reg;
                state_next = S_APP3;
            end
            S_APP3:
            begin
                twr.we = 1'b1;
                twr.addr = wtask_reg;
                twr.wdata = rec_reg;
                twr.wdata.rprev = qrec_reg.tail;
                rec_next.rprev = qrec_reg.tail;
                state_next = S_APP4;
            end
            S_APP4:
            begin
                case (ret_reg)
                    R_TICK:  state_next = S_TCK3;
                    R_SLICE: state_next = S_SCH0;
                    default: state_next = S_DONE;
                endcase
            end
            // remove wtask from its queue; rec_reg holds its record
            S_REM0:
            begin
                rec_next = trd;
                qraddr = trd.prio;
                state_next = S_REM1;
            end
            S_REM1:
            begin
                state_next = S_REM2;
            end
            S_REM2:
            begin
                qrec_next = qrd;
                if (qcount_reg[wprio] > CW'(1))
                begin
                    if (wtask_reg == qrd.head)
                    begin
                        qrec_next.head = rec_reg.rnext;
                        state_next = S_REM5;
                    end
                    else
                    begin
                        traddr = rec_reg.rprev;
                        state_next = S_REM3;
                    end
                end
                else
                begin
                    state_next = S_REM7;
                end
            end
            S_REM3:
            begin
                twr.we = 1'b1;
                twr.addr = rec_reg.rprev;
                twr.wdata = trd;
                twr.wdata.rnext = rec_reg.rnext;
                state_next = S_REM5;
            end
            S_REM5:
            begin
                if (wtask_reg == qrec_reg.tail)
                begin
                    qrec_next.tail = rec_reg.rprev;
                    state_next = S_REM7;
                end
                else
                begin
                    traddr = rec_reg.rnext;
                    state_next = S_REM6;
                end
            end
            S_REM6:
            begin
                twr.we = 1'b1;
                twr.addr = rec_reg.rnext;
                twr.wdata = trd;
                twr.wdata.rprev = rec_reg.rprev;
                state_next = S_REM7;
            end
            S_REM7:
            begin
                qwr.we = 1'b1;
                qwr.addr = wprio;
                qwr.wdata = qrec_reg;
                if (qcount_reg[wprio] != '0)
                begin
                    qcount_next[wprio] = qcount_reg[wprio] - CW'(1);
                end
                if (qcount_reg[wprio] <= CW'(1)) bitmap_next[wprio] = 1'b0;
                inready_next[wtask_reg] = 1'b0;
                if (ret_reg == R_SLICE)
                begin
                    traddr = wtask_reg;
                    state_next = S_SLC1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // delay list append
            S_DTL0:
            begin
                traddr = dltail_reg;
                state_next = S_DTL1;
            end
            S_DTL1:
            begin
                twr.we = 1'b1;
                twr.addr = dltail_reg;
                twr.wdata = trd;
                twr.wdata.dnext = tid_reg;
                state_next = S_DLY0;
            end
            S_DLY0:
            begin
                if (dllen_reg == '0) dlhead_next = tid_reg;
                dltail_next = tid_reg;
                dllen_next = dllen_reg + CW'(1);
                delayed_next[tid_reg] = 1'b1;
                state_next = S_DONE;
            end
            // wake: walk the delay list to find the task
            S_WAK0:
            begin
                traddr = wt_reg;
                state_next = (n_reg == '0) ? S_DONE : S_WAK1;
            end
            S_WAK1:
            begin
                wnx_next = trd.dnext;
                if (wt_reg == tid_reg)
                begin
                    ret_next = R_DONE;
                    state_next = S_UNL0;
                end
                else
                begin
                    wprev_next = wt_reg;
                    hprev_next = 1'b1;
                    wt_next = trd.dnext;
                    n_next = n_reg - CW'(1);
                    state_next = S_WAK0;
                end
            end
            // unlink wt from the delay list, next link in wnx
            S_UNL0:
            begin
                traddr = wprev_reg;
                state_next = S_UNL1;
            end
            S_UNL1:
            begin
                if (!hprev_reg)
                begin
                    dlhead_next = wnx_reg;
                end
                else
                begin
                    twr.we = 1'b1;
                    twr.addr = wprev_reg;
                    twr.wdata = trd;
                    twr.wdata.dnext = wnx_reg;
                end
                if (wt_reg == dltail_reg) dltail_next = wprev_reg;
                dllen_next = dllen_reg - CW'(1);
                delayed_next[wt_reg] = 1'b0;
                state_next = S_UNL2;
            end
            S_UNL2:
            begin
                state_next = (ret_reg == R_TICK) ? S_TCK2 : S_DONE;
            end
            // tick walk
            S_TCK0:
            begin
                traddr = wt_reg;
                state_next = (n_reg == '0) ? S_SLC0 : S_TCK1;
            end
            S_TCK1:
            begin
                rec_next = trd;
                rec_next.remain = trd.remain - 32'd1;
                wnx_next = trd.dnext;
                twr.we = 1'b1;
                twr.addr = wt_reg;
                twr.wdata = trd;
                twr.wdata.remain = trd.remain - 32'd1;
                if (trd.remain == 32'd1)
                begin
                    ret_next = R_TICK;
                    state_next = S_UNL0;
                end
                else
                begin
                    wprev_next = wt_reg;
                    hprev_next = 1'b1;
                    state_next = S_TCK3;
                end
            end
            S_TCK2:
            begin
                // expired task: append if not ready
                traddr = wt_reg;
                wtask_next = wt_reg;
                if (!inready_reg[wt_reg])
                begin
                    ret_next = R_TICK;
                    state_next = S_APP0;
                end
                else
                begin
                    state_next = S_TCK3;
                end
                // rec_reg still holds this task's record from the walk
            end
            S_TCK3:
            begin
                wt_next = wnx_reg;
                n_next = n_reg - CW'(1);
                state_next = S_TCK0;
            end
            // time slice of the current task
            S_SLC0:
            begin
                wtask_next = cur_reg;
                traddr = cur_reg;
                ticktot_next = ticktot_reg + 32'd1;
                if (slice_reg[cur_reg] == 8'd1)
                begin
                    slice_next[cur_reg] = reload_reg;
                    if (inready_reg[cur_reg])
                    begin
                        ret_next = R_SLICE;
                        state_next = S_REM0;
                    end
                    else
                    begin
                        state_next = S_SCH0;
                    end
                end
                else
                begin
                    slice_next[cur_reg] = slice_reg[cur_reg] - 8'd1;
                    state_next = S_SCH0;
                end
            end
            S_SLC1:
            begin
                // record reread after removal for the append
                rec_next = trd;
                state_next = S_APP0;
            end
            // schedule
            S_SCH0:
            begin
                qraddr = first_set(bitmap_reg);
                state_next = S_SCH1;
            end
            S_SCH1:
            begin
                state_next = S_SCH2;
                if (lock_reg == 8'd0 && bitmap_reg != '0 && qrd.head != cur_reg)
                begin
                    cur_next = qrd.head;
                    sw_next = 1'b1;
                end
            end
            S_SCH2:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || !out_stall)
                begin
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= R_DONE;
            reload_reg  <= SLICE_RESET;
            bitmap_reg  <= '0;
            inready_reg <= '0;
            delayed_reg <= '0;
            cur_reg     <= '0;
            lock_reg    <= '0;
            ticktot_reg <= '0;
            dllen_reg   <= '0;
            ov_reg      <= 1'b0;
            for (int i = 0; i < NUM_PRIOS; i++) qcount_reg[i] <= '0;
            for (int i = 0; i < NUM_TASKS; i++) slice_reg[i] <= SLICE_RESET;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            if (cfg_we) reload_reg <= (cfg_wdata == 8'd0) ? 8'd1 : cfg_wdata;
            bitmap_reg  <= bitmap_next;
            inready_reg <= inready_next;
            delayed_reg <= delayed_next;
            cur_reg     <= cur_next;
            lock_reg    <= lock_next;
            ticktot_reg <= ticktot_next;
            dllen_reg   <= dllen_next;
            ov_reg      <= ov_next;
            qcount_reg  <= qcount_next;
            slice_reg   <= slice_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg   <= act_next;
        tid_reg   <= tid_next;
        prio_reg  <= prio_next;
        ticks_reg <= ticks_next;
        dlhead_reg <= dlhead_next;
        dltail_reg <= dltail_next;
        n_reg     <= n_next;
        wt_reg    <= wt_next;
        wprev_reg <= wprev_next;
        wnx_reg   <= wnx_next;
        hprev_reg <= hprev_next;
        wtask_reg <= wtask_next;
        rec_reg   <= rec_next;
        qrec_reg  <= qrec_next;
        sw_reg    <= sw_next;
    end

    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)
    `ASSERT_SAME(a_bitmap_matches_count, clk, rst_n, 1'b1,
        (bitmap_reg == '0) == (inready_reg == '0))
    `ASSERT_NEXT(a_lock_holds_current, clk, rst_n,
        lock_reg != 8'd0 && state_reg != S_IDLE && state_reg != S_DISP, cur_reg == $past(cur_reg))
endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench of the priority task scheduler with a scheduler model
module tb_top;
    import pts_pkg::*;

    typedef struct packed {
        logic       sw;
        logic [3:0] run;
        logic       empty;
        logic [7:0] lock;
    } sched_res_t;

    class sched_scoreboard;
        logic [7:0]  reload;
        logic [31:0] bitmap;
        logic [3:0]  qhead [32];
        logic [3:0]  qtail [32];
        int          qcnt [32];
        logic [3:0]  rnext [16];
        logic [3:0]  rprev [16];
        logic [4:0]  tprio [16];
        bit          rdy [16];
        logic [31:0] remain [16];
        logic [3:0]  dnext [16];
        bit          dly [16];
        logic [3:0]  dhead, dtail;
        int          dlen;
        logic [7:0]  slice [16];
        logic [3:0]  cur;
        logic [7:0]  lockc;
        logic [31:0] ticks;
        sched_res_t  pending [$];
        int          errors;

        function new();
            reload = SLICE_RESET;
            bitmap = '0;
            dhead = '0;
            dtail = '0;
            dlen = 0;
            cur = '0;
            lockc = '0;
            ticks = '0;
            errors = 0;
            for (int i = 0; i < 32; i++)
            begin
                qhead[i] = '0;
                qtail[i] = '0;
                qcnt[i] = 0;
            end
            for (int i = 0; i < 16; i++)
            begin
                rnext[i] = '0;
                rprev[i] = '0;
                tprio[i] = '0;
                rdy[i] = 0;
                remain[i] = '0;
                dnext[i] = '0;
                dly[i] = 0;
                slice[i] = SLICE_RESET;
            end
        endfunction

        function void set_reload(logic [7:0] v);
            reload = (v == 8'd0) ? 8'd1 : v;
        endfunction

        function void enqueue(logic [3:0] t);
            logic [4:0] p;
            p = tprio[t];
            if (qcnt[p] == 0)
                qhead[p] = t;
            else
            begin
                rnext[qtail[p]] = t;
                rprev[t] = qtail[p];
            end
            qtail[p] = t;
            qcnt[p]++;
            bitmap[p] = 1'b1;
            rdy[t] = 1;
        endfunction

        function void dequeue(logic [3:0] t);
            logic [4:0] p;
            p = tprio[t];
            if (qcnt[p] > 1)
            begin
                if (t == qhead[p])
                    qhead[p] = rnext[t];
                else
                    rnext[rprev[t]] = rnext[t];
                if (t == qtail[p])
                    qtail[p] = rprev[t];
                else
                    rprev[rnext[t]] = rprev[t];
            end
            if (qcnt[p] > 0)
                qcnt[p]--;
            if (qcnt[p] == 0)
                bitmap[p] = 1'b0;
            rdy[t] = 0;
        endfunction

        function void unlink_delay(logic [3:0] t, bit has_prev, logic [3:0] prev);
            if (!has_prev)
                dhead = dnext[t];
            else
                dnext[prev] = dnext[t];
            if (t == dtail)
                dtail = prev;
            dlen--;
            dly[t] = 0;
        endfunction

        function logic pick();
            int p;
            if (lockc != 0 || bitmap == 0)
                return 1'b0;
            p = 0;
            while (!bitmap[p])
                p++;
            if (qhead[p] != cur)
            begin
                cur = qhead[p];
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function logic run_tick();
            int n;
            logic [3:0] t, prev, nx;
            bit has_prev;
            n = dlen;
            t = dhead;
            prev = '0;
            has_prev = 0;
            while (n > 0)
            begin
                nx = dnext[t];
                remain[t] = remain[t] - 32'd1;
                if (remain[t] == 0)
                begin
                    unlink_delay(t, has_prev, prev);
                    if (!rdy[t])
                        enqueue(t);
                end
                else
                begin
                    prev = t;
                    has_prev = 1;
                end
                t = nx;
                n--;
            end
            slice[cur] = slice[cur] - 8'd1;
            if (slice[cur] == 0)
            begin
                slice[cur] = reload;
                if (rdy[cur])
                begin
                    dequeue(cur);
                    enqueue(cur);
                end
            end
            ticks++;
            return pick();
        endfunction

        function void note_request(logic [2:0] act, logic [3:0] t, logic [4:0] p,
                                   logic [31:0] d);
            sched_res_t r;
            int n;
            logic [3:0] c, prev;
            bit has_prev;
            r.sw = 1'b0;
            case (act)
                ACT_READY:
                    if (!rdy[t])
                    begin
                        tprio[t] = p;
                        enqueue(t);
                    end
                ACT_UNREADY:
                    if (rdy[t])
                        dequeue(t);
                ACT_DELAY:
                begin
                    remain[t] = (d == 0) ? 32'd1 : d;
                    if (!dly[t])
                    begin
                        if (dlen == 0)
                            dhead = t;
                        else
                            dnext[dtail] = t;
                        dtail = t;
                        dlen++;
                        dly[t] = 1;
                    end
                end
                ACT_WAKE:
                    if (dly[t])
                    begin
                        n = dlen;
                        c = dhead;
                        prev = '0;
                        has_prev = 0;
                        while (n > 0)
                        begin
                            if (c == t)
                            begin
                                unlink_delay(t, has_prev, prev);
                                break;
                            end
                            prev = c;
                            has_prev = 1;
                            c = dnext[c];
                            n--;
                        end
                    end
                ACT_TICK:
                    r.sw = run_tick();
                ACT_LOCK:
                    if (lockc != LOCK_MAX)
                        lockc++;
                ACT_UNLOCK:
                    if (lockc != 0)
                    begin
                        lockc--;
                        if (lockc == 0)
                            r.sw = pick();
                    end
                default:
                    r.sw = pick();
            endcase
            r.run = cur;
            r.empty = (bitmap == 0);
            r.lock = lockc;
            pending.push_back(r);
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t e;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = pending.pop_front();
            if (got !== e)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected sw=%0d run=%0d empty=%0d lock=%0d, %s",
                             e.sw, e.run, e.empty, e.lock,
                             $sformatf("got sw=%0d run=%0d empty=%0d lock=%0d",
                                       got.sw, got.run, got.empty, got.lock));
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  action;
    logic [3:0]  task_id;
    logic [4:0]  task_prio;
    logic [31:0] delay_ticks;
    logic        out_valid;
    logic        out_stall;
    logic        switch_now;
    logic [3:0]  running_task;
    logic        none_ready;
    logic [7:0]  lock_depth;

    sched_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles;

    priority_task_scheduler_unit dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .in_valid(in_valid), .in_stall(in_stall), .action(action),
        .task_id(task_id), .task_prio(task_prio), .delay_ticks(delay_ticks),
        .out_valid(out_valid), .out_stall(out_stall), .switch_now(switch_now),
        .running_task(running_task), .none_ready(none_ready), .lock_depth(lock_depth)
    );

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // receiver: random stall, check at the accepting edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result({switch_now, running_task, none_ready, lock_depth});
            out_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000)
        begin
            $display("priority_task_scheduler_unit test failed");
            $finish;
        end
    end

    task automatic send_request(logic [2:0] act, logic [3:0] t, logic [4:0] p,
                                logic [31:0] d);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action <= act;
        task_id <= t;
        task_prio <= p;
        delay_ticks <= d;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.note_request(act, t, p, d);
    endtask

    task automatic drain_and_config(logic [7:0] v);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reload(v);
    endtask

    task automatic random_request();
        int k;
        logic [3:0] t;
        logic [4:0] p;
        logic [31:0] d;
        k = $urandom_range(99);
        t = 4'($urandom_range(15));
        p = 5'($urandom_range(31));
        d = ($urandom_range(9) == 0) ? $urandom() : $urandom_range(6);
        if (k < 22)
            send_request(ACT_READY, t, p, d);
        else if (k < 32)
            send_request(ACT_UNREADY, t, p, d);
        else if (k < 44)
            send_request(ACT_DELAY, t, p, d);
        else if (k < 50)
            send_request(ACT_WAKE, t, p, d);
        else if (k < 80)
            send_request(ACT_TICK, t, p, d);
        else if (k < 87)
            send_request(ACT_LOCK, t, p, d);
        else if (k < 94)
            send_request(ACT_UNLOCK, t, p, d);
        else
            send_request(ACT_SCHEDULE, t, p, d);
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        in_valid = 1'b0;
        action = '0;
        task_id = '0;
        task_prio = '0;
        delay_ticks = '0;
        out_stall = 1'b0;
        quiet_cycles = 0;
        send_idle_pct = 15;
        recv_idle_pct = 55;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, every action, corner cases
        send_request(ACT_SCHEDULE, 4'd0, 5'd0, 32'd0);
        send_request(ACT_UNREADY, 4'd3, 5'd0, 32'd0);
        send_request(ACT_WAKE, 4'd3, 5'd0, 32'd0);
        send_request(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_READY, 4'd15, 5'd31, 32'hFFFF_FFFF);
        send_request(ACT_READY, 4'd15, 5'd0, 32'd0);
        send_request(ACT_READY, 4'd0, 5'd31, 32'd0);
        send_request(ACT_READY, 4'd5, 5'd0, 32'd0);
        send_request(ACT_SCHEDULE, 4'd0, 5'd0, 32'd0);
        send_request(ACT_DELAY, 4'd7, 5'd3, 32'd0);
        send_request(ACT_DELAY, 4'd5, 5'd3, 32'd2);
        send_request(ACT_DELAY, 4'd9, 5'd3, 32'hFFFF_FFFF);
        send_request(ACT_DELAY, 4'd7, 5'd3, 32'd3);
        send_request(ACT_TICK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_WAKE, 4'd9, 5'd0, 32'd0);
        send_request(ACT_LOCK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_TICK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_TICK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);
        send_request(ACT_UNREADY, 4'd5, 5'd0, 32'd0);
        for (int i = 0; i < 260; i++)
            send_request(ACT_LOCK, 4'd0, 5'd0, 32'd0);
        for (int i = 0; i < 255; i++)
            send_request(ACT_UNLOCK, 4'd0, 5'd0, 32'd0);

        // slice reload of zero and the extremes
        drain_and_config(8'd0);
        for (int i = 0; i < 30; i++)
            send_request(ACT_TICK, 4'd0, 5'd0, 32'd0);
        drain_and_config(8'd255);
        for (int i = 0; i < 400; i++)
        begin
            if (i == 200)
            begin
                send_idle_pct = 55;
                recv_idle_pct = 15;
            end
            random_request();
        end
        drain_and_config(8'd2);
        for (int i = 0; i < 400; i++)
            random_request();
        drain_and_config(8'd1);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 200; i++)
            random_request();
        drain_and_config(8'd3);
        for (int i = 0; i < 200; i++)
            random_request();

        in_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (sb.errors == 0)
            $display("priority_task_scheduler_unit test passed");
        else
            $display("priority_task_scheduler_unit test failed");
        $finish;
    end
endmodule

// ===== priority_task_scheduler_unit.f =====
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_task_mem.sv
rtl/pts_queue_mem.sv
rtl/priority_task_scheduler_unit.sv
tb/tb_top.sv
